>>> src/spq_pkg.sv
// Package with the shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

	localparam int DEPTH_DEFAULT = 512;
	localparam int COUNT_W = 10;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef struct packed {
		logic [31:0] prio;
		logic [8:0]  key;
		logic [8:0]  left;
		logic [8:0]  right;
	} entry_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] new_priority;
		logic [8:0]  new_key_ref;
		logic [8:0]  new_left_ref;
		logic [8:0]  new_right_ref;
	} req_t;

	typedef struct packed {
		logic               popped_valid;
		logic [31:0]        popped_priority;
		logic [8:0]         popped_key_ref;
		logic [8:0]         popped_left_ref;
		logic [8:0]         popped_right_ref;
		logic               underflow;
		logic               overflow;
		logic [COUNT_W-1:0] entry_count;
		logic               queue_empty;
		logic [31:0]        head_priority;
		logic [8:0]         head_key_ref;
	} res_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		logic   head_ins;
		entry_t new_ent;
	} ctrl_t;

endpackage

>>> src/spq_cell.sv
// One slot of the sorted chain: holds an entry and inserts, shifts or keeps it on each request.
`timescale 1ns / 1ps
module spq_cell import spq_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 10
) (
	input  logic          clk,
	input  ctrl_t         ctrl,
	input  logic [CW-1:0] count,
	input  entry_t        prev_ent,
	input  logic          prev_after,
	input  entry_t        next_ent,
	output entry_t        ent,
	output logic          after
);

	entry_t ent_q;
	logic   occupied;
	logic   less;

	assign occupied = CW'(IDX) < count;
	assign less     = occupied && (ent_q.prio < ctrl.new_ent.prio);

	// The head cell follows only the head decision; later cells also yield to a pushed priority no larger than theirs.
	if (IDX == 0) begin : g_head
		assign after = ctrl.head_ins;
	end else begin : g_body
		assign after = ctrl.head_ins || !less;
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && after) begin
			ent_q <= prev_after ? prev_ent : ctrl.new_ent;
		end else if (ctrl.pop) begin
			ent_q <= next_ent;
		end
	end

	assign ent = ent_q;

endmodule

>>> src/sorted_priority_queue.sv
// Top level of the sorted priority queue built as a chain of shifting cells.
`timescale 1ns / 1ps
// The queue holds up to DEPTH entries in a row of cells kept in ascending priority
// order, and takes one push or pop request per clock cycle unless an untaken response
// holds req_ready low: every cell compares its priority with the pushed one in
// parallel and then inserts, shifts or holds in the same edge. The result of a
// request appears in the response register on the cycle after acceptance, and a new
// request is taken in the same cycle as the previous response is taken. No clearing
// pass is needed after reset; occupancy follows from the entry count.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int CW = $clog2(DEPTH + 1);

	entry_t        ents  [DEPTH];
	logic          after [DEPTH];
	ctrl_t         ctrl;
	logic [CW-1:0] count_q;
	logic          res_valid_q;
	logic          popped_valid_q;
	entry_t        popped_q;
	logic          underflow_q;
	logic          overflow_q;
	logic          accept;
	logic          is_push;
	logic          full;
	logic          empty;
	logic [CW+COUNT_W-1:0] count_ext;

	assign req_ready = !res_valid_q || res_ready;
	assign accept    = req_valid && req_ready;
	assign is_push   = req.mode == MODE_PUSH;
	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;

	always_comb begin
		ctrl.push          = accept && is_push && !full;
		ctrl.pop           = accept && !is_push && !empty;
		ctrl.head_ins      = empty || (req.new_priority < ents[0].prio);
		ctrl.new_ent.prio  = req.new_priority;
		ctrl.new_ent.key   = req.new_key_ref;
		ctrl.new_ent.left  = req.new_left_ref;
		ctrl.new_ent.right = req.new_right_ref;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t prev_ent;
		logic   prev_after;
		entry_t next_ent;

		if (i == 0) begin : g_first
			assign prev_ent   = '0;
			assign prev_after = 1'b0;
		end else begin : g_prev
			assign prev_ent   = ents[i-1];
			assign prev_after = after[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_ent = ents[i];
		end else begin : g_next
			assign next_ent = ents[i+1];
		end

		spq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.prev_ent   (prev_ent),
			.prev_after (prev_after),
			.next_ent   (next_ent),
			.ent        (ents[i]),
			.after      (after[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctrl.push) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_valid_q <= ctrl.pop;
			popped_q       <= ctrl.pop ? ents[0] : '0;
			underflow_q    <= !is_push && empty;
			overflow_q     <= is_push && full;
		end
	end

	// Head and count come straight from the state, which changes only with a new request.
	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	always_comb begin
		res.popped_valid     = popped_valid_q;
		res.popped_priority  = popped_q.prio;
		res.popped_key_ref   = popped_q.key;
		res.popped_left_ref  = popped_q.left;
		res.popped_right_ref = popped_q.right;
		res.underflow        = underflow_q;
		res.overflow         = overflow_q;
		res.entry_count      = count_ext[COUNT_W-1:0];
		res.queue_empty      = empty;
		res.head_priority    = empty ? 32'd0 : ents[0].prio;
		res.head_key_ref     = empty ? 9'd0 : ents[0].key;
	end

	assign res_valid = res_valid_q;

`ifndef SYNTHESIS
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && overflow_q |-> full)
		else $error("Overflow reported while the queue is not full.");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && underflow_q |-> empty && !popped_valid_q)
		else $error("Underflow reported while the queue holds entries.");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_push && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("Accepted push did not raise the entry count.");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_push && !empty |=> popped_valid_q && count_q == $past(count_q) - CW'(1))
		else $error("Accepted pop did not lower the entry count.");
`endif

endmodule

>>> bench/spq_checker.sv
// Checker that predicts each sorted priority queue response and compares it with the block.
`timescale 1ns / 1ps
module spq_checker import spq_pkg::*; #(
	parameter int QDEPTH = DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic res_valid,
	input  logic res_ready,
	input  res_t res,
	output int   errors,
	output int   pending
);

	entry_t slots [QDEPTH];
	int     held;
	res_t   expected_results [$];
	res_t   want;
	res_t   predicted;
	string  diffs;
	int     responses_seen;

	function automatic string field_diff(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			return $sformatf(" %s exp %0h got %0h", name, e, a);
		end
		return "";
	endfunction

	task automatic apply_request(input req_t r, output res_t o);
		int pos;
		int i;
		o = '0;
		if (r.mode == MODE_PUSH) begin
			if (held >= QDEPTH) begin
				o.overflow = 1'b1;
			end else begin
				if (held == 0 || r.new_priority < slots[0].prio) begin
					pos = 0;
				end else begin
					pos = 1;
					while (pos < held && slots[pos].prio < r.new_priority) begin
						pos++;
					end
				end
				for (i = held; i > pos; i--) begin
					slots[i] = slots[i - 1];
				end
				slots[pos].prio  = r.new_priority;
				slots[pos].key   = r.new_key_ref;
				slots[pos].left  = r.new_left_ref;
				slots[pos].right = r.new_right_ref;
				held++;
			end
		end else begin
			if (held == 0) begin
				o.underflow = 1'b1;
			end else begin
				o.popped_valid     = 1'b1;
				o.popped_priority  = slots[0].prio;
				o.popped_key_ref   = slots[0].key;
				o.popped_left_ref  = slots[0].left;
				o.popped_right_ref = slots[0].right;
				for (i = 1; i < held; i++) begin
					slots[i - 1] = slots[i];
				end
				held--;
			end
		end
		o.entry_count = COUNT_W'(held);
		o.queue_empty = (held == 0);
		if (held != 0) begin
			o.head_priority = slots[0].prio;
			o.head_key_ref  = slots[0].key;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			expected_results.delete();
			errors = 0;
			responses_seen = 0;
		end else begin
			if (res_valid && res_ready) begin
				responses_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("checker: response %0d arrived with none expected: %h",
							responses_seen, res);
					end
				end else begin
					want = expected_results.pop_front();
					diffs = {
						field_diff("popped_valid", want.popped_valid, res.popped_valid),
						field_diff("popped_priority", want.popped_priority, res.popped_priority),
						field_diff("popped_key_ref", want.popped_key_ref, res.popped_key_ref),
						field_diff("popped_left_ref", want.popped_left_ref, res.popped_left_ref),
						field_diff("popped_right_ref", want.popped_right_ref,
							res.popped_right_ref),
						field_diff("underflow", want.underflow, res.underflow),
						field_diff("overflow", want.overflow, res.overflow),
						field_diff("entry_count", want.entry_count, res.entry_count),
						field_diff("queue_empty", want.queue_empty, res.queue_empty),
						field_diff("head_priority", want.head_priority, res.head_priority),
						field_diff("head_key_ref", want.head_key_ref, res.head_key_ref)
					};
					if (diffs != "") begin
						errors++;
						if (errors <= 10) begin
							$display("checker: response %0d mismatch:%s", responses_seen, diffs);
						end
					end
				end
			end
			if (req_valid && req_ready) begin
				apply_request(req, predicted);
				expected_results.push_back(predicted);
			end
		end
		pending = expected_results.size();
	end

endmodule

>>> bench/tb.sv
// Testbench top that drives requests into the sorted priority queue and reports the verdict.
`timescale 1ns / 1ps
module tb;
	import spq_pkg::*;

	localparam int QDEPTH = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic res_valid;
	logic res_ready;
	res_t res;
	int   errors;
	int   pending;

	int   idle_odds;
	bit   calm;
	int   stall_left;
	int   cycles;
	int   fill_level;
	int   peak_level;
	int   n_push;
	int   n_pop;
	int   n_full_push;
	int   n_empty_pop;

	sorted_priority_queue #(.DEPTH(QDEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	spq_checker #(.QDEPTH(QDEPTH)) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
			stall_left = $urandom_range(1, 12) - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	function automatic logic [31:0] pick_priority();
		case ($urandom_range(0, 6))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2, 3: return 32'($urandom_range(0, 15));
			4: return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [8:0] pick_ref();
		case ($urandom_range(0, 7))
			0: return 9'h000;
			1: return 9'h1FF;
			default: return 9'($urandom_range(0, 511));
		endcase
	endfunction

	function automatic req_t random_request(bit as_push);
		req_t r;
		r.mode          = as_push ? MODE_PUSH : MODE_POP;
		r.new_priority  = pick_priority();
		r.new_key_ref   = pick_ref();
		r.new_left_ref  = pick_ref();
		r.new_right_ref = pick_ref();
		return r;
	endfunction

	task automatic send(input req_t r);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		if (r.mode == MODE_PUSH) begin
			n_push++;
			if (fill_level >= QDEPTH) begin
				n_full_push++;
			end else begin
				fill_level++;
			end
		end else begin
			n_pop++;
			if (fill_level == 0) begin
				n_empty_pop++;
			end else begin
				fill_level--;
			end
		end
		if (fill_level > peak_level) begin
			peak_level = fill_level;
		end
		if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic run_mixed(input int count, input int push_pct);
		repeat (count) begin
			send(random_request($urandom_range(0, 99) < push_pct));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		idle_odds = 8;
		calm = 1'b0;
		fill_level = 0;
		peak_level = 0;
		n_push = 0;
		n_pop = 0;
		n_full_push = 0;
		n_empty_pop = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send('{MODE_POP, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF, 9'h1FF});
		send('{MODE_PUSH, 32'd100, 9'd1, 9'd0, 9'd0});
		send('{MODE_PUSH, 32'd100, 9'd2, 9'd3, 9'd4});
		send('{MODE_PUSH, 32'd100, 9'd3, 9'd5, 9'd6});
		send('{MODE_PUSH, 32'd50, 9'd4, 9'h1FF, 9'd0});
		send('{MODE_PUSH, 32'd0, 9'h1FF, 9'h1FF, 9'h1FF});
		send('{MODE_PUSH, 32'hFFFF_FFFF, 9'd5, 9'd0, 9'h1FF});
		send('{MODE_PUSH, 32'hFFFF_FFFF, 9'd6, 9'd7, 9'd8});
		send('{MODE_PUSH, 32'd75, 9'd9, 9'd10, 9'd11});
		send('{MODE_PUSH, 32'd0, 9'd7, 9'd0, 9'd0});
		send('{MODE_PUSH, 32'd100, 9'd12, 9'd13, 9'd14});
		repeat (12) begin
			send(random_request(1'b0));
		end

		run_mixed(400, 60);

		idle_odds = 0;
		while (fill_level < QDEPTH / 2) begin
			send(random_request(1'b1));
		end
		idle_odds = 20;
		while (fill_level < QDEPTH) begin
			send(random_request(1'b1));
		end
		repeat (12) begin
			send(random_request(1'b1));
		end
		run_mixed(20, 50);
		while (fill_level < QDEPTH) begin
			send(random_request(1'b1));
		end
		repeat (4) begin
			send(random_request(1'b1));
		end

		idle_odds = 6;
		while (fill_level > 0) begin
			send(random_request(1'b0));
		end
		repeat (6) begin
			send(random_request(1'b0));
		end

		idle_odds = 3;
		run_mixed(300, 50);

		calm = 1'b1;
		idle_odds = 0;
		run_mixed(250, 55);
		req_valid <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("summary: %0d requests, %0d pushes and %0d pops", n_push + n_pop, n_push,
			n_pop);
		$display("summary: peak fill %0d of %0d, %0d pushes while full, %0d pops while empty",
			peak_level, QDEPTH, n_full_push, n_empty_pop);
		if (errors == 0 && pending == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
